// ===== rtl/kll_pkg.sv =====
// types, constants and the power-of-three table for the level capacity calculator
// no dependencies
package kll_pkg;

  localparam int LVL_W   = 6;
  localparam int K_W     = 16;
  localparam int MINW_W  = 8;
  localparam int TOT_W   = 22;
  localparam int DEPTH_W = 5;
  localparam int ROM_DEPTH = 30;
  localparam int QUO_W   = 17;
  localparam int DEN_W   = 48;
  localparam int NUM_W   = 47;
  localparam int CNT_W   = $clog2(QUO_W + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [K_W-1:0]    SKETCH_K_RST  = 16'd200;
  localparam logic [MINW_W-1:0] MIN_WIDTH_RST = 8'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_SKETCH_K  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 1'd1;

  typedef struct packed {
    logic [LVL_W-1:0] level_count;
    logic [LVL_W-1:0] level_height;
  } kll_in_t;

  typedef struct packed {
    logic [TOT_W-1:0] total_capacity;
    logic [K_W-1:0]   level_size;
    logic             height_invalid;
  } kll_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PASS1,
    ST_WAIT1,
    ST_PASS2,
    ST_WAIT2,
    ST_ACCUM,
    ST_DONE
  } kll_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start1;
    logic start2;
    logic accum;
  } kll_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic deep;
    logic last_level;
    logic div_done;
  } kll_stat_t;

  // 3^d for d in 0..30
  function automatic logic [DEN_W-1:0] pow3(input logic [DEPTH_W-1:0] d);
    logic [DEN_W-1:0] p;
    case (d)
      5'd0:  p = 48'd1;
      5'd1:  p = 48'd3;
      5'd2:  p = 48'd9;
      5'd3:  p = 48'd27;
      5'd4:  p = 48'd81;
      5'd5:  p = 48'd243;
      5'd6:  p = 48'd729;
      5'd7:  p = 48'd2187;
      5'd8:  p = 48'd6561;
      5'd9:  p = 48'd19683;
      5'd10: p = 48'd59049;
      5'd11: p = 48'd177147;
      5'd12: p = 48'd531441;
      5'd13: p = 48'd1594323;
      5'd14: p = 48'd4782969;
      5'd15: p = 48'd14348907;
      5'd16: p = 48'd43046721;
      5'd17: p = 48'd129140163;
      5'd18: p = 48'd387420489;
      5'd19: p = 48'd1162261467;
      5'd20: p = 48'd3486784401;
      5'd21: p = 48'd10460353203;
      5'd22: p = 48'd31381059609;
      5'd23: p = 48'd94143178827;
      5'd24: p = 48'd282429536481;
      5'd25: p = 48'd847288609443;
      5'd26: p = 48'd2541865828329;
      5'd27: p = 48'd7625597484987;
      5'd28: p = 48'd22876792454961;
      5'd29: p = 48'd68630377364883;
      5'd30: p = 48'd205891132094649;
      default: p = 48'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/kll_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on kll_pkg
module kll_div
  import kll_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] low_r;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           fits;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_r, low_r[QUO_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  // control: step count and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(QUO_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  // remainder and quotient; the quotient always fits QUO_W bits, so the
  // upper dividend bits start out below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num >> QUO_W);
      low_r <= num[QUO_W-1:0];
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_r <= {low_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/kll_datapath.sv =====
// datapath: config registers, level loop registers, operand select, divider,
// rounding, minimum clamp and accumulation; depends on kll_pkg and kll_div
module kll_datapath
  import kll_pkg::*;
#(
  parameter int MAX_LEVELS = 61
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kll_cmd_t              cmd,
  output kll_stat_t             stat,
  input  kll_in_t               in_word,
  output kll_out_t              out_word,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [K_W-1:0]    sketch_k_r;
  logic [MINW_W-1:0] min_width_r;
  logic [LVL_W-1:0]  count_r;
  logic [LVL_W-1:0]  height_r;
  logic [LVL_W-1:0]  h_r;
  logic [TOT_W-1:0]  total_r;
  logic [K_W-1:0]    size_r;
  logic              invalid_r;

  logic [LVL_W-1:0]   count_sat;
  logic [LVL_W-1:0]   depth;
  logic [LVL_W-1:0]   rest;
  logic               deep;
  logic [DEPTH_W-1:0] op_d;
  logic [K_W-1:0]     op_k;
  logic [LVL_W-1:0]   shamt;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic               div_done;
  logic [QUO_W-1:0]   quo;
  logic [QUO_W-1:0]   quo_inc;
  logic [K_W-1:0]     rounded;
  logic [K_W-1:0]     cap;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sketch_k_r  <= SKETCH_K_RST;
      min_width_r <= MIN_WIDTH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SKETCH_K:  sketch_k_r  <= cfg_data[K_W-1:0];
        CFG_MIN_WIDTH: min_width_r <= cfg_data[MINW_W-1:0];
        default: ;
      endcase
    end
  end

  // level count saturated to the supported maximum
  assign count_sat = (in_word.level_count > LVL_W'(MAX_LEVELS)) ?
                     LVL_W'(MAX_LEVELS) : in_word.level_count;

  // depth of the current level and the split for deep levels
  always_comb begin
    depth = count_r - h_r - 1'b1;
    deep  = (depth > LVL_W'(ROM_DEPTH));
    rest  = depth - {1'b0, depth[LVL_W-1:1]};
    if (cmd.start2) begin
      op_d = rest[DEPTH_W-1:0];
      op_k = rounded;
    end else begin
      op_d = deep ? depth[LVL_W-1:1] : depth[DEPTH_W-1:0];
      op_k = sketch_k_r;
    end
    shamt = {1'b0, op_d} + 1'b1;
    num   = NUM_W'(op_k) << shamt;
    den   = pow3(op_d);
  end

  kll_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start1 | cmd.start2),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // round half up, then clamp to the minimum width
  always_comb begin
    quo_inc = quo + 1'b1;
    rounded = quo_inc[QUO_W-1:1];
    cap     = (rounded < K_W'(min_width_r)) ? K_W'(min_width_r) : rounded;
  end

  // item registers and accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count_r   <= count_sat;
      height_r  <= in_word.level_height;
      invalid_r <= (in_word.level_height >= count_sat);
      h_r       <= '0;
      total_r   <= '0;
      size_r    <= '0;
    end else if (cmd.accum) begin
      total_r <= total_r + TOT_W'(cap);
      if (h_r == height_r) begin
        size_r <= cap;
      end
      h_r <= h_r + 1'b1;
    end
  end

  assign stat.count_zero = (count_r == '0);
  assign stat.deep       = deep;
  assign stat.last_level = (h_r == count_r - 1'b1);
  assign stat.div_done   = div_done;

  assign out_word.total_capacity = total_r;
  assign out_word.level_size     = size_r;
  assign out_word.height_invalid = invalid_r;

endmodule

// ===== rtl/kll_ctrl.sv =====
// controller: sequences the level loop, the two scaling passes and the result
// depends on kll_pkg
module kll_ctrl
  import kll_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output kll_cmd_t  cmd,
  input  kll_stat_t stat
);

  kll_state_t state_r;
  kll_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = stat.count_zero ? ST_DONE : ST_PASS1;
      end
      ST_PASS1: begin
        cmd.start1 = 1'b1;
        state_nxt  = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (stat.div_done) begin
          state_nxt = stat.deep ? ST_PASS2 : ST_ACCUM;
        end
      end
      ST_PASS2: begin
        cmd.start2 = 1'b1;
        state_nxt  = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (stat.div_done) begin
          state_nxt = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = stat.last_level ? ST_DONE : ST_PASS1;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

// ===== rtl/kll_level_capacity_calc.sv =====
// top level of the level capacity calculator
// depends on kll_pkg, kll_ctrl, kll_datapath (and kll_div below it)
//
// A word is taken when start is high while busy is low; the result word is
// shown on out_word for exactly one cycle with out_valid high and cannot be
// held off, so it must be captured then. For each item the serial divider
// runs once for every level of depth 30 or less and twice for every deeper
// level, over at most 61 levels, before the result is presented; the divider
// yields one quotient bit per cycle over 17 steps. Config writes are taken on
// any cycle but must only be made while busy is low.
module kll_level_capacity_calc
  import kll_pkg::*;
#(
  parameter int MAX_LEVELS = 61
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  kll_in_t               in_word,
  output logic                  out_valid,
  output kll_out_t              out_word,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  kll_cmd_t  cmd;
  kll_stat_t stat;

  kll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  kll_datapath #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_word),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
